// ===== rtl/core/fsrc_pkg.sv =====
// fsrc_pkg: shared types, constants and formation offset rom
`timescale 1ns / 1ps
package fsrc_pkg;

    localparam int NUM_FORMATIONS_DEF      = 10;
    localparam int SLOTS_PER_FORMATION_DEF = 20;
    localparam int TRIG_ITERATIONS_DEF     = 16;

    localparam int MAP_W_BITS = 11;
    localparam int MAP_H_BITS = 12;
    localparam int CFG_BITS   = 12;

    localparam logic [MAP_W_BITS-1:0] MAP_W_RESET = 11'd64;
    localparam logic [MAP_H_BITS-1:0] MAP_H_RESET = 12'd64;

    // register indexes on the config port
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 32;

    localparam int ROM_ROWS = 6;
    localparam int ROM_COLS = 20;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } off_t;

    localparam off_t ROM [ROM_ROWS][ROM_COLS] = '{
        '{'{0,0},'{0,36},'{0,72},'{0,108},'{0,144},'{0,180},'{0,216},'{0,252},'{0,288},
          '{0,324},'{0,360},'{0,396},'{0,432},'{0,468},'{0,504},'{0,540},'{0,576},
          '{0,612},'{0,648},'{0,684}},
        '{'{0,0},'{48,0},'{-48,0},'{0,48},'{0,84},'{0,120},'{0,156},'{0,192},'{0,228},
          '{0,264},'{0,300},'{0,336},'{0,372},'{0,408},'{0,444},'{0,480},'{0,516},
          '{0,552},'{0,588},'{0,624}},
        '{'{0,-36},'{48,-24},'{-48,-24},'{48,24},'{-48,24},'{0,36},'{48,48},'{-48,48},
          '{0,72},'{48,72},'{-48,72},'{0,108},'{48,96},'{-48,96},'{0,144},'{48,120},
          '{-48,120},'{0,180},'{48,144},'{-48,144}},
        '{'{0,0},'{64,0},'{-64,0},'{128,0},'{0,48},'{64,48},'{-64,48},'{128,48},'{0,96},
          '{64,96},'{-64,96},'{128,96},'{0,144},'{64,144},'{-64,144},'{128,144},
          '{0,192},'{64,192},'{-64,192},'{128,192}},
        '{'{0,0},'{64,0},'{-64,0},'{0,48},'{64,48},'{-64,48},'{0,96},'{64,96},'{-64,96},
          '{0,144},'{64,144},'{-64,144},'{0,192},'{64,192},'{-64,192},'{0,240},
          '{64,240},'{-64,240},'{0,288},'{64,288}},
        '{'{0,0},'{0,-36},'{-64,0},'{64,0},'{-32,48},'{32,48},'{0,24},'{0,48},'{0,72},
          '{0,96},'{0,120},'{0,144},'{0,168},'{0,192},'{0,216},'{0,240},'{0,264},
          '{0,288},'{0,312},'{0,336}}
    };

    // rows and slots with no entry give a zero offset
    function automatic off_t rom_offset(input logic [3:0] row, input logic [4:0] slot);
        off_t r;
        r = '0;
        if (int'(row) < ROM_ROWS && int'(slot) < ROM_COLS) begin
            r = ROM[row[2:0]][slot];
        end
        return r;
    endfunction

    // bit-serial root state: remainder, rsq*q and the partial quotient
    typedef struct packed {
        logic [62:0] e;
        logic [49:0] p;
        logic [15:0] q;
    } root_t;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic               form_ok;
        off_t               off;
        logic               x_neg;
        logic               y_neg;
        logic               zero;
    } item_t;

endpackage

// ===== rtl/core/formation_slot_rotate_clamp.sv =====
// formation_slot_rotate_clamp: rotated formation slot placement, clamped to the map
`timescale 1ns / 1ps
// throughput: one item per cycle while the output is not stalled; every stage is one register, the unit-vector roots
//   resolve one quotient bit per stage so their stage count adds to the latency
// a full output register that is not taken holds the whole pipeline
// reset: aresetn synchronous active low, clears all valid bits and loads the map
//   size registers with 64 tiles each; payload registers are not reset
module formation_slot_rotate_clamp #(
    parameter int NUM_FORMATIONS      = fsrc_pkg::NUM_FORMATIONS_DEF,
    parameter int SLOTS_PER_FORMATION = fsrc_pkg::SLOTS_PER_FORMATION_DEF,
    parameter int TRIG_ITERATIONS     = fsrc_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write port
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [fsrc_pkg::CFG_BITS-1:0]      cfg_wdata,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // dest_x[15:0] dest_y[31:16] from_x[47:32] from_y[63:48]
    // formation_index[67:64] slot_index[72:68], zero fill to 80
    input  logic [fsrc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_x[15:0] out_y[31:16]
    output logic [fsrc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import fsrc_pkg::*;

    // number of resolved quotient bits, one per root stage
    localparam int N = (TRIG_ITERATIONS < 16) ? TRIG_ITERATIONS : 16;

    logic en;

    // map size registers
    logic [MAP_W_BITS-1:0] map_w_reg;
    logic [MAP_H_BITS-1:0] map_h_reg;

    // stage 1: decode, direction, rom lookup
    logic               s1_vld_reg;
    item_t              s1_item_reg, s1_item_next;
    logic signed [16:0] s1_dx_reg, s1_dy_reg;

    // stage 2: magnitudes and signs
    logic               s2_vld_reg;
    item_t              s2_item_reg, s2_item_next;
    logic [15:0]        s2_ax_reg, s2_ay_reg;

    // stage 3: squares
    logic               s3_vld_reg;
    item_t              s3_item_reg;
    logic [31:0]        s3_axx_reg, s3_ayy_reg;

    // root pipeline, index 0 is the loaded state
    logic               rt_vld_reg  [N+1];
    item_t              rt_item_reg [N+1];
    logic [32:0]        rt_rsq_reg  [N+1];
    root_t              rt_s_reg    [N+1];
    root_t              rt_c_reg    [N+1];

    // product stage
    logic               mu_vld_reg;
    item_t              mu_item_reg;
    logic signed [32:0] mu_oxc_reg, mu_oys_reg, mu_oxs_reg, mu_oyc_reg;
    logic signed [16:0] sin_v, cos_v;

    // sum stage
    logic               su_vld_reg;
    item_t              su_item_reg;
    logic signed [19:0] su_vx_reg, su_vy_reg;
    logic signed [33:0] num_x, num_y;
    logic signed [33:0] tr_x, tr_y;

    // output register
    logic               out_vld_reg;
    logic signed [15:0] out_x_reg, out_y_reg, out_x_next, out_y_next;

    // one quotient bit: accept b if (2P + rsq*2^b)*2^b fits the remainder
    function automatic root_t root_step(input root_t r, input logic [32:0] rsq, input int b);
        logic [67:0] d;
        root_t       n;
        d = (68'(r.p) << (b + 1)) + (68'(rsq) << (2 * b));
        n = r;
        if (d <= 68'(r.e)) begin
            n.e = r.e - d[62:0];
            n.p = r.p + (50'(rsq) << b);
            n.q = r.q | (16'(1) << b);
        end
        return n;
    endfunction

    // whole pipeline moves when the output slot is free or being taken
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_w_reg <= MAP_W_RESET;
            map_h_reg <= MAP_H_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAP_WIDTH:  map_w_reg <= cfg_wdata[MAP_W_BITS-1:0];
                REG_MAP_HEIGHT: map_h_reg <= cfg_wdata[MAP_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage 1 decode
    always_comb begin
        logic [3:0] form;
        logic [4:0] slot;
        form = s_tdata[67:64];
        slot = s_tdata[72:68];
        if (int'(slot) > SLOTS_PER_FORMATION - 1) begin
            slot = 5'(SLOTS_PER_FORMATION - 1);
        end
        s1_item_next         = '0;
        s1_item_next.dest_x  = s_tdata[15:0];
        s1_item_next.dest_y  = s_tdata[31:16];
        s1_item_next.from_x  = s_tdata[47:32];
        s1_item_next.from_y  = s_tdata[63:48];
        s1_item_next.form_ok = int'(form) < NUM_FORMATIONS;
        s1_item_next.off     = rom_offset(form, slot);
    end

    // stage 2 direction signs and zero flag
    always_comb begin
        s2_item_next       = s1_item_reg;
        s2_item_next.x_neg = s1_dx_reg[16];
        s2_item_next.y_neg = s1_dy_reg[16];
        s2_item_next.zero  = (s1_dx_reg == '0) && (s1_dy_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            rt_vld_reg[0] <= 1'b0;
        end else if (en) begin
            s1_vld_reg    <= s_tvalid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            rt_vld_reg[0] <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_item_reg <= s1_item_next;
            s1_dx_reg   <= 17'(s1_item_next.from_x) - 17'(s1_item_next.dest_x);
            s1_dy_reg   <= 17'(s1_item_next.from_y) - 17'(s1_item_next.dest_y);

            s2_item_reg <= s2_item_next;
            s2_ax_reg <= s1_dx_reg[16] ? 16'(-s1_dx_reg) : s1_dx_reg[15:0];
            s2_ay_reg <= s1_dy_reg[16] ? 16'(-s1_dy_reg) : s1_dy_reg[15:0];

            s3_item_reg <= s2_item_reg;
            s3_axx_reg  <= s2_ax_reg * s2_ax_reg;
            s3_ayy_reg  <= s2_ay_reg * s2_ay_reg;

            // load the roots: remainder starts at a^2 * 2^30
            rt_item_reg[0] <= s3_item_reg;
            rt_rsq_reg[0]  <= 33'(s3_axx_reg) + 33'(s3_ayy_reg);
            rt_s_reg[0]    <= '{e: 63'(s3_axx_reg) << 30, p: '0, q: '0};
            rt_c_reg[0]    <= '{e: 63'(s3_ayy_reg) << 30, p: '0, q: '0};
        end
    end

    // one stage per quotient bit, msb first
    for (genvar k = 0; k < N; k++) begin : g_root
        localparam int B = 15 - k;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                rt_vld_reg[k+1] <= rt_vld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rt_item_reg[k+1] <= rt_item_reg[k];
                rt_rsq_reg[k+1]  <= rt_rsq_reg[k];
                rt_s_reg[k+1]    <= root_step(rt_s_reg[k], rt_rsq_reg[k], B);
                rt_c_reg[k+1]    <= root_step(rt_c_reg[k], rt_rsq_reg[k], B);
            end
        end
    end

    // signed sine and cosine; no direction means facing -pi/2
    always_comb begin
        if (rt_item_reg[N].zero) begin
            sin_v = -17'sd32768;
            cos_v = 17'sd0;
        end else begin
            sin_v = rt_item_reg[N].x_neg ? -$signed({1'b0, rt_s_reg[N].q})
                                         : $signed({1'b0, rt_s_reg[N].q});
            cos_v = rt_item_reg[N].y_neg ? -$signed({1'b0, rt_c_reg[N].q})
                                         : $signed({1'b0, rt_c_reg[N].q});
        end
    end

    // exact sums, then divide by 2^15 rounding toward zero
    always_comb begin
        num_x = 34'(mu_oys_reg) - 34'(mu_oxc_reg);
        num_y = 34'(mu_oxs_reg) + 34'(mu_oyc_reg);
        tr_x  = (num_x + (num_x[33] ? 34'sd32767 : 34'sd0)) >>> 15;
        tr_y  = (num_y + (num_y[33] ? 34'sd32767 : 34'sd0)) >>> 15;
    end

    // clamp to at least 8, then to at most the map edge
    always_comb begin
        logic signed [19:0] hi_x, hi_y, tx, ty;
        hi_x = $signed(20'({map_w_reg, 4'b0000}));
        hi_y = $signed(20'({map_h_reg, 3'b000}) + 20'({map_h_reg, 2'b00}));
        tx   = (su_vx_reg < 20'sd8) ? 20'sd8 : su_vx_reg;
        ty   = (su_vy_reg < 20'sd8) ? 20'sd8 : su_vy_reg;
        tx   = (tx > hi_x) ? hi_x : tx;
        ty   = (ty > hi_y) ? hi_y : ty;
        if (su_item_reg.form_ok) begin
            out_x_next = tx[15:0];
            out_y_next = ty[15:0];
        end else begin
            // unknown formation passes the source through unclamped
            out_x_next = su_item_reg.from_x;
            out_y_next = su_item_reg.from_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_vld_reg  <= 1'b0;
            su_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            mu_vld_reg  <= rt_vld_reg[N];
            su_vld_reg  <= mu_vld_reg;
            out_vld_reg <= su_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mu_item_reg <= rt_item_reg[N];
            mu_oxc_reg  <= rt_item_reg[N].off.x * cos_v;
            mu_oys_reg  <= rt_item_reg[N].off.y * sin_v;
            mu_oxs_reg  <= rt_item_reg[N].off.x * sin_v;
            mu_oyc_reg  <= rt_item_reg[N].off.y * cos_v;

            su_item_reg <= mu_item_reg;
            su_vx_reg   <= 20'($signed(tr_x[18:0])) + 20'(mu_item_reg.dest_x);
            su_vy_reg   <= 20'($signed(tr_y[18:0])) + 20'(mu_item_reg.dest_y);

            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};

endmodule

// ===== rtl/core/fsrc_checker.sv =====
// fsrc_checker: port-level checks for formation_slot_rotate_clamp, bound to the top level
`timescale 1ns / 1ps
module fsrc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_we,
    input logic                               cfg_addr,
    input logic [fsrc_pkg::CFG_BITS-1:0]      cfg_wdata,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [fsrc_pkg::IN_TDATA_W-1:0]    s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [fsrc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import fsrc_pkg::*;

    // a result that is not taken stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input side is ready exactly when the output slot frees
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output slot");

    // a stalled output also stalls intake
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item accepted during output stall");

endmodule

bind formation_slot_rotate_clamp fsrc_checker u_fsrc_checker (.*);
